>>> hdl/three_word_key_hash_table_core_defines.svh
// Assertion macros shared by the checker of the three-word-key hash table.
// Both macros assume a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef THREE_WORD_KEY_HASH_TABLE_CORE_DEFINES_SVH
`define THREE_WORD_KEY_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TWKHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication, disabled while reset is asserted
`define TWKHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

>>> hdl/twkht_pkg.sv
// Package for the three-word-key hash table: command and result types,
// operation and status codes, default sizes. No dependencies.
package twkht_pkg;

    // Default sizes
    localparam int DEF_BUCKETS    = 1024;
    localparam int DEF_WAYS       = 8;
    localparam int DEF_VALUE_BITS = 32;

    // Minor hash share is BUCKETS / MINOR_DIV
    localparam int MINOR_DIV = 10;

    // Operation codes
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key_word0;
        logic [31:0] key_word1;
        logic [31:0] key_word2;
        logic [31:0] value_in;
    } t_cmd;

    typedef struct packed {
        logic        hit;
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [9:0]  bucket_index;
    } t_result;

endpackage

>>> hdl/three_word_key_hash_table_core.sv
// Top level of the three-word-key hash table: sequencer, bucket valid-row
// memory and slot memory. Depends on twkht_pkg and twkht_arith.
//
// Usage:
//   Command channel: i_cmd is taken at a rising edge where start is high and
//   busy is low. kind selects lookup, add or remove on the 96-bit key.
//   Result channel: o_result is valid for exactly one cycle while o_done is
//   high; the receiver cannot stall it and must take it in that cycle.
//   Sequence: o_done is high in the cycle in which busy drops, so each
//   command finishes before another one is taken. The work before that
//   cycle takes four hash steps (two products on the shared multiplier,
//   sum and clamp, row base product with the valid-row read), a step that
//   latches the row base, a read and a compare per way through the single
//   slot memory port, and a write-back step; the result register follows.
//   Reset: the valid-row memory is cleared one bucket per cycle, so busy
//   stays high after reset is released until every bucket is cleared; the
//   table is then empty. Slot key and value contents are not cleared.
//   Adds go to the lowest free way; an add to a full bucket is dropped.
module three_word_key_hash_table_core #(
    parameter int BUCKETS    = twkht_pkg::DEF_BUCKETS,
    parameter int WAYS       = twkht_pkg::DEF_WAYS,
    parameter int VALUE_BITS = twkht_pkg::DEF_VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  twkht_pkg::t_cmd    i_cmd,
    output logic               o_done,
    output twkht_pkg::t_result o_result
);

    localparam int S2     = BUCKETS / twkht_pkg::MINOR_DIV;
    localparam int S1     = BUCKETS - S2;
    localparam int OPB_W  = $clog2(BUCKETS + 1);
    localparam int SUM_W  = OPB_W + 1;
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W  = 96 + VALUE_BITS;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_MUL0     = 4'd2;
    localparam logic [3:0] S_MUL1     = 4'd3;
    localparam logic [3:0] S_MUL2     = 4'd4;
    localparam logic [3:0] S_MUL3     = 4'd5;
    localparam logic [3:0] S_BASE     = 4'd6;
    localparam logic [3:0] S_SCAN_RD  = 4'd7;
    localparam logic [3:0] S_SCAN_CMP = 4'd8;
    localparam logic [3:0] S_UPDATE   = 4'd9;

    // Control registers
    logic [3:0]       r_state, n_state;
    logic [BKT_W-1:0] r_clr, n_clr;
    logic [WAY_W-1:0] r_way, n_way;
    logic             r_found, n_found;
    logic             r_free_ok, n_free_ok;
    logic             r_done, n_done;

    // Payload registers
    logic [WAY_W-1:0]      r_found_way, n_found_way;
    logic [WAY_W-1:0]      r_free_way, n_free_way;
    logic [VALUE_BITS-1:0] r_fval, n_fval;
    twkht_pkg::t_cmd       r_cmd, n_cmd;
    twkht_pkg::t_result    r_result, n_result;
    logic [OPB_W-1:0]      r_t1, n_t1;
    logic [BKT_W-1:0]      r_bucket, n_bucket;
    logic [SLOT_W-1:0]     r_base, n_base;

    // Memories
    logic [WAYS-1:0]  vld_mem [BUCKETS];
    logic [ENT_W-1:0] slot_mem [SLOTS];
    logic [WAYS-1:0]  r_vrow;
    logic [ENT_W-1:0] r_slot_q;

    // Memory port controls
    logic              vld_we, vld_re;
    logic [BKT_W-1:0]  vld_waddr;
    logic [WAYS-1:0]   vld_wdata;
    logic              slot_we, slot_re;
    logic [SLOT_W-1:0] slot_addr;
    logic [ENT_W-1:0]  slot_wdata;

    // Shared arithmetic unit
    logic                arith_load;
    logic [31:0]         arith_a;
    logic [OPB_W-1:0]    arith_b;
    logic [32+OPB_W-1:0] arith_prod;
    logic [OPB_W-1:0]    arith_quot;

    // Helpers
    logic [SUM_W-1:0] hash_sum;
    logic [95:0]      slot_key;
    logic             key_eq;
    logic [63:0]      val_in64;
    logic [63:0]      fval64;

    twkht_arith #(
        .B_W (OPB_W)
    ) u_arith (
        .i_clk  (i_clk),
        .i_load (arith_load),
        .i_a    (arith_a),
        .i_b    (arith_b),
        .o_prod (arith_prod),
        .o_quot (arith_quot)
    );

    assign hash_sum = SUM_W'(r_t1) + SUM_W'(arith_quot);
    assign slot_key = r_slot_q[ENT_W-1:VALUE_BITS];
    assign key_eq   = (slot_key == {r_cmd.key_word0, r_cmd.key_word1, r_cmd.key_word2});
    assign val_in64 = 64'(r_cmd.value_in);
    assign fval64   = 64'(r_fval);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_way       = r_way;
        n_found     = r_found;
        n_free_ok   = r_free_ok;
        n_done      = 1'b0;
        n_found_way = r_found_way;
        n_free_way  = r_free_way;
        n_fval      = r_fval;
        n_cmd       = r_cmd;
        n_result    = r_result;
        n_t1        = r_t1;
        n_bucket    = r_bucket;
        n_base      = r_base;

        arith_load  = 1'b0;
        arith_a     = r_cmd.key_word0;
        arith_b     = OPB_W'(S1);

        vld_we      = 1'b0;
        vld_re      = 1'b0;
        vld_waddr   = r_bucket;
        vld_wdata   = r_vrow;
        slot_we     = 1'b0;
        slot_re     = 1'b0;
        slot_addr   = r_base + SLOT_W'(r_way);
        slot_wdata  = {r_cmd.key_word0, r_cmd.key_word1, r_cmd.key_word2,
                       val_in64[VALUE_BITS-1:0]};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_way     = '0;
                    n_state   = S_MUL0;
                end
            end
            S_CLEAR: begin
                vld_we    = 1'b1;
                vld_waddr = r_clr;
                vld_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL0: begin
                // major term product
                arith_load = 1'b1;
                arith_a    = r_cmd.key_word0;
                arith_b    = OPB_W'(S1);
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                // keep major term, start minor term product
                n_t1       = arith_quot;
                arith_load = 1'b1;
                arith_a    = r_cmd.key_word1;
                arith_b    = OPB_W'(S2);
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                // sum and clamp to the last bucket
                if (hash_sum > SUM_W'(BUCKETS - 1)) begin
                    n_bucket = BKT_W'(BUCKETS - 1);
                end else begin
                    n_bucket = BKT_W'(hash_sum);
                end
                n_state = S_MUL3;
            end
            S_MUL3: begin
                // row base and valid-row read
                arith_load = 1'b1;
                arith_a    = 32'(WAYS);
                arith_b    = OPB_W'(r_bucket);
                vld_re     = 1'b1;
                n_state    = S_BASE;
            end
            S_BASE: begin
                n_base  = arith_prod[SLOT_W-1:0];
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                slot_re = 1'b1;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // exact match on valid ways, lowest free way
                if (r_vrow[r_way]) begin
                    if (key_eq && !r_found) begin
                        n_found     = 1'b1;
                        n_found_way = r_way;
                        n_fval      = r_slot_q[VALUE_BITS-1:0];
                    end
                end else if (!r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_way = r_way;
                end
                if (r_way == WAY_W'(WAYS - 1)) begin
                    n_state = S_UPDATE;
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_UPDATE: begin
                n_result.hit          = r_found;
                n_result.value_out    = r_found ? fval64[31:0] : 32'd0;
                n_result.bucket_index = 10'(r_bucket);
                slot_addr             = r_base + SLOT_W'(r_free_way);
                case (r_cmd.kind)
                    twkht_pkg::KIND_ADD: begin
                        if (r_found) begin
                            n_result.status = twkht_pkg::ST_PRESENT;
                        end else if (!r_free_ok) begin
                            n_result.status = twkht_pkg::ST_FULL;
                        end else begin
                            n_result.status = twkht_pkg::ST_DONE;
                            slot_we         = 1'b1;
                            vld_we          = 1'b1;
                            vld_wdata       = r_vrow | (WAYS'(1) << r_free_way);
                        end
                    end
                    twkht_pkg::KIND_REMOVE: begin
                        if (r_found) begin
                            n_result.status = twkht_pkg::ST_DONE;
                            vld_we          = 1'b1;
                            vld_wdata       = r_vrow & ~(WAYS'(1) << r_found_way);
                        end else begin
                            n_result.status = twkht_pkg::ST_ABSENT;
                        end
                    end
                    default: begin
                        // lookup, and the unused code behaves the same
                        n_result.status = r_found ? twkht_pkg::ST_DONE
                                                  : twkht_pkg::ST_ABSENT;
                    end
                endcase
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, synchronous reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_way     <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_way     <= n_way;
            r_found   <= n_found;
            r_free_ok <= n_free_ok;
            r_done    <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_found_way <= n_found_way;
        r_free_way  <= n_free_way;
        r_fval      <= n_fval;
        r_cmd       <= n_cmd;
        r_result    <= n_result;
        r_t1        <= n_t1;
        r_bucket    <= n_bucket;
        r_base      <= n_base;
    end

    // Valid-row memory, one row of way bits per bucket
    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            vld_mem[vld_waddr] <= vld_wdata;
        end
        if (vld_re) begin
            r_vrow <= vld_mem[r_bucket];
        end
    end

    // Slot memory: key words and value per way
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_addr] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_q <= slot_mem[slot_addr];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> hdl/twkht_arith.sv
// Shared multiplier with exact floor division by 2^32-1 of its product.
// Used by the hash table sequencer for both hash terms and the row base.
// Depends on nothing.
module twkht_arith #(
    parameter int B_W = 11
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [31:0]        i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [32+B_W-1:0]  o_prod,
    output logic [B_W-1:0]     o_quot
);

    logic [32+B_W-1:0] r_prod;
    logic [B_W-1:0]    prod_hi;
    logic [32:0]       hi_lo_sum;

    // Product register, loaded when the sequencer issues an operation
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_a * (32+B_W)'(i_b);
        end
    end

    // x = q*2^32 + r = q*(2^32-1) + (q + r), and q + r < 2*(2^32-1)
    assign prod_hi   = r_prod[32+B_W-1:32];
    assign hi_lo_sum = 33'(prod_hi) + {1'b0, r_prod[31:0]};
    assign o_quot    = prod_hi + B_W'(hi_lo_sum >= 33'h0_FFFF_FFFF);
    assign o_prod    = r_prod;

endmodule

>>> hdl/twkht_checker.sv
// Port-level checker for the three-word-key hash table, bound to the top.
// Depends on twkht_pkg and three_word_key_hash_table_core_defines.svh.
`include "three_word_key_hash_table_core_defines.svh"

module twkht_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input twkht_pkg::t_cmd    i_cmd,
    input logic               o_done,
    input twkht_pkg::t_result o_result
);

    logic hit_status_ok;

    // A hit only ever reports done or already present
    assign hit_status_ok = (o_result.status == twkht_pkg::ST_DONE) ||
                           (o_result.status == twkht_pkg::ST_PRESENT);

    // A result transfer follows a busy cycle
    `TWKHT_ASSERT_IMP(a_done_after_busy, o_done, $past(busy))

    // An accepted command makes the block busy
    `TWKHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // A miss returns no value
    `TWKHT_ASSERT_IMP(a_miss_zero, o_done && !o_result.hit, o_result.value_out == 32'd0)

    // Status agrees with the hit flag
    `TWKHT_ASSERT_IMP(a_status_hit, o_done && o_result.hit, hit_status_ok)

endmodule

bind three_word_key_hash_table_core twkht_checker u_twkht_checker (.*);

>>> bench/tb_three_word_key_hash_table_core.sv
// Testbench for three_word_key_hash_table_core: directed and random lookup, add and
// remove commands, checked against a scoreboard that mirrors the bucketed table.
// Depends on twkht_pkg and the core RTL; self-contained otherwise.
module tb_three_word_key_hash_table_core;

    localparam int BUCKETS     = twkht_pkg::DEF_BUCKETS;
    localparam int WAYS        = twkht_pkg::DEF_WAYS;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int MINOR_SHARE = BUCKETS / twkht_pkg::MINOR_DIV;
    localparam int MAJOR_SHARE = BUCKETS - MINOR_SHARE;
    localparam int OP_CYCLES   = 2 * WAYS + 7;
    localparam int RANDOM_CMDS = 1750;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Mirror of the table contents plus the queue of results still owed
    class table_scoreboard;
        bit                 slot_used[SLOTS];
        bit [95:0]          slot_key[SLOTS];
        bit [31:0]          slot_value[SLOTS];
        twkht_pkg::t_result owed_results[$];
        int                 errors;

        // Both hash terms exactly in 64 bits, sum clamped to the last bucket
        function int unsigned hash_bucket(logic [31:0] w0, logic [31:0] w1);
            bit [63:0] major_term;
            bit [63:0] minor_term;
            bit [63:0] sum;
            major_term = ({32'd0, w0} * 64'(MAJOR_SHARE)) / 64'h0000_0000_FFFF_FFFF;
            minor_term = ({32'd0, w1} * 64'(MINOR_SHARE)) / 64'h0000_0000_FFFF_FFFF;
            sum = major_term + minor_term;
            if (sum > 64'(BUCKETS - 1)) begin
                sum = 64'(BUCKETS - 1);
            end
            return int'(sum);
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void apply_cmd(twkht_pkg::t_cmd c);
            int unsigned        bkt;
            int                 found;
            int                 free_way;
            int                 s;
            bit [95:0]          key;
            twkht_pkg::t_result r;
            bkt      = hash_bucket(c.key_word0, c.key_word1);
            key      = {c.key_word0, c.key_word1, c.key_word2};
            found    = -1;
            free_way = -1;
            for (int w = 0; w < WAYS; w++) begin
                s = bkt * WAYS + w;
                if (slot_used[s]) begin
                    if (found < 0 && slot_key[s] == key) found = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            r = '0;
            r.bucket_index = 10'(bkt);
            if (found >= 0) begin
                r.hit       = 1'b1;
                r.value_out = slot_value[bkt * WAYS + found];
            end
            case (c.kind)
                twkht_pkg::KIND_ADD: begin
                    if (found >= 0) begin
                        r.status = twkht_pkg::ST_PRESENT;
                    end else if (free_way < 0) begin
                        r.status = twkht_pkg::ST_FULL;
                    end else begin
                        s = bkt * WAYS + free_way;
                        slot_used[s]  = 1'b1;
                        slot_key[s]   = key;
                        slot_value[s] = c.value_in;
                        r.status      = twkht_pkg::ST_DONE;
                    end
                end
                twkht_pkg::KIND_REMOVE: begin
                    if (found >= 0) begin
                        slot_used[bkt * WAYS + found] = 1'b0;
                        r.status = twkht_pkg::ST_DONE;
                    end else begin
                        r.status = twkht_pkg::ST_ABSENT;
                    end
                end
                default: begin
                    // lookup, and the unused code behaves as one
                    r.status = (found >= 0) ? twkht_pkg::ST_DONE : twkht_pkg::ST_ABSENT;
                end
            endcase
            owed_results.insert(owed_results.size(), r);
        endfunction

        // Compare one result transfer with the oldest owed result
        function void check_result(twkht_pkg::t_result got);
            twkht_pkg::t_result want;
            if (owed_results.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.value_out !== want.value_out) begin
                $error("value_out: expected %h, actual %h",
                       want.value_out, got.value_out);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.bucket_index !== want.bucket_index) begin
                $error("bucket_index: expected %0d, actual %0d",
                       want.bucket_index, got.bucket_index);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    twkht_pkg::t_cmd    i_cmd   = '0;
    logic               busy;
    logic               o_done;
    twkht_pkg::t_result o_result;

    int              cycle_count = 0;
    table_scoreboard sb = new();

    // Hot regions: a few keys that share a bucket, so buckets fill and keys repeat
    bit [31:0] hot_w0[4];
    bit [31:0] hot_w1[4];
    bit [31:0] hot_w2[4];

    three_word_key_hash_table_core #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .VALUE_BITS (twkht_pkg::DEF_VALUE_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[three_word_key_hash_table_core] ERROR");
            $finish;
        end
    end

    // Result monitor: every strobed cycle is one transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (o_done !== 1'b1) begin
                $error("o_done is unknown");
                sb.errors++;
            end
            sb.check_result(o_result);
        end
    end

    function automatic twkht_pkg::t_cmd make_cmd(logic [1:0] kind, logic [31:0] w0,
                                                 logic [31:0] w1, logic [31:0] w2,
                                                 logic [31:0] value);
        twkht_pkg::t_cmd c;
        c.kind      = kind;
        c.key_word0 = w0;
        c.key_word1 = w1;
        c.key_word2 = w2;
        c.value_in  = value;
        return c;
    endfunction

    // Present a command and hold it until the accepting edge; start stays high
    task automatic send_cmd(twkht_pkg::t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.apply_cmd(c);
    endtask

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic void new_hot_regions();
        for (int r = 0; r < 4; r++) begin
            hot_w0[r] = $urandom_range(0, 32'hFFFF_FFF0);
            hot_w1[r] = $urandom;
            hot_w2[r] = $urandom;
        end
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 2))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic twkht_pkg::t_cmd random_cmd();
        int          pick;
        int          r;
        logic [1:0]  kind;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        pick = $urandom_range(0, 99);
        if (pick < 40)      kind = twkht_pkg::KIND_ADD;
        else if (pick < 65) kind = twkht_pkg::KIND_LOOKUP;
        else if (pick < 92) kind = twkht_pkg::KIND_REMOVE;
        else                kind = KIND_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            r  = $urandom_range(0, 3);
            w0 = hot_w0[r] + $urandom_range(0, 3);
            w1 = hot_w1[r];
            w2 = hot_w2[r] ^ $urandom_range(0, 3);
        end else if (pick < 9) begin
            w0 = $urandom;
            w1 = $urandom;
            w2 = $urandom;
        end else begin
            w0 = corner_word();
            w1 = corner_word();
            w2 = corner_word();
        end
        return make_cmd(kind, w0, w1, w2, $urandom);
    endfunction

    initial begin
        int burst;
        int sent;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: misses, duplicates, removes, unused code, hash clamp
        send_cmd(make_cmd(twkht_pkg::KIND_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h1234_5678));
        send_cmd(make_cmd(twkht_pkg::KIND_ADD, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(twkht_pkg::KIND_ADD, 32'd0, 32'd0, 32'd0, 32'h0000_0001));
        send_cmd(make_cmd(twkht_pkg::KIND_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0));
        send_cmd(make_cmd(KIND_UNUSED, 32'd0, 32'd0, 32'd0, 32'hA5A5_A5A5));
        send_cmd(make_cmd(twkht_pkg::KIND_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0));
        send_cmd(make_cmd(twkht_pkg::KIND_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0));
        send_cmd(make_cmd(twkht_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'd0));
        send_cmd(make_cmd(twkht_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'd0));
        send_cmd(make_cmd(twkht_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0,
                          32'hFFFF_FFFF, 32'd0));
        // Fill bucket zero; the ninth add overflows it
        for (int k = 1; k <= WAYS + 1; k++) begin
            send_cmd(make_cmd(twkht_pkg::KIND_ADD, 32'd0, 32'd0, 32'(k), 32'h100 + 32'(k)));
        end
        // Free a middle way, then a new key must land there
        send_cmd(make_cmd(twkht_pkg::KIND_REMOVE, 32'd0, 32'd0, 32'd3, 32'd0));
        send_cmd(make_cmd(twkht_pkg::KIND_ADD, 32'd0, 32'd0, 32'd10, 32'hDEAD_BEEF));
        send_cmd(make_cmd(twkht_pkg::KIND_LOOKUP, 32'd0, 32'd0, 32'd10, 32'd0));
        send_cmd(make_cmd(twkht_pkg::KIND_LOOKUP, 32'd0, 32'd0, 32'(WAYS + 1), 32'd0));
        drain();

        // Random: bursts with gaps, long back-to-back stretches now and then
        new_hot_regions();
        sent = 0;
        while (sent < RANDOM_CMDS) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_CMDS; i++) begin
                send_cmd(random_cmd());
                sent++;
            end
            if (sent % 350 < burst) begin
                drain();
                new_hot_regions();
            end else begin
                idle($urandom_range(1, 40));
            end
        end

        // Wrap up once nothing is outstanding
        drain();
        repeat (OP_CYCLES + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[three_word_key_hash_table_core] OK");
        end else begin
            $display("[three_word_key_hash_table_core] ERROR");
        end
        $finish;
    end

endmodule
